// File: rtl/core/sws_pkg.sv
// Package: constants, types and register codes for the sliding window statistics block.
package sws_pkg;

	localparam int WindowMaxDefault  = 64;
	localparam int SampleBitsDefault = 16;
	localparam int MinLength         = 3;
	localparam int LenBits           = 7;

	// Register byte addresses
	localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

	// Sequencer states, one-hot
	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_CLEAR = 9'b000000010,
		ST_READ  = 9'b000000100,
		ST_SCAN1 = 9'b000001000,
		ST_DIV   = 9'b000010000,
		ST_SCAN2 = 9'b000100000,
		ST_DIVSQ = 9'b001000000,
		ST_SQRT  = 9'b010000000,
		ST_OUT   = 9'b100000000
	} sws_state_t;

	// Operations of the shared divide and square root unit
	typedef enum logic [2:0] {
		OP_MEAN = 3'b001,
		OP_DEV  = 3'b010,
		OP_SQ   = 3'b100
	} sws_op_t;

endpackage

// File: rtl/core/sliding_window_statistics.sv
// Top level: windowed statistics of a Q8.8 sample stream with an iterative shared unit.
// The datapath is two scans of the one-write, one-read window memory, one shared restoring
// divider (one quotient bit per cycle) and one shared digit-by-digit root.
// s_tready is low while an item is at work or a result waits, so no new item is taken before
// the last one is through.
// Reset: asynchronous, active low; a clearing pass zeroes the memory after reset, after
// every window_length write and for every clear item, with s_tready low meanwhile.
module sliding_window_statistics #(
	parameter int WINDOW_MAX  = sws_pkg::WindowMaxDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] sample
	input  logic        s_tuser,  // [0] clear_window
	output logic        m_tvalid,
	input  logic        m_tready,
	// [16:0] velocity, [34:17] acceleration, [50:35] window_min, [66:51] window_max,
	// [88:67] window_sum, [104:89] window_mean, [120:105] std_dev,
	// [136:121] root_mean_square, [153:137] min_velocity, [170:154] max_velocity,
	// [188:171] min_acceleration, [206:189] max_acceleration, [207] zero fill
	output logic [207:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sws_pkg::*;

	localparam int SAMPLE_BITS = SampleBitsDefault;
	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int SUMW = SAMPLE_BITS + CW + 1;
	localparam int SQW = 2 * SAMPLE_BITS + CW + 1;
	localparam int DW = SQW;
	localparam int QSTEPS = SQW;
	localparam int RW = SQW / 2 + 1;

	logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0] rd_s1;

	sws_state_t state_q;
	sws_op_t    op_q;
	logic [CW-1:0] len_q, wp_q, k_q, clr_q;
	logic [LenBits-1:0] len_w;
	logic signed [SAMPLE_BITS-1:0] s_in;
	logic clear_q;
	logic [SAMPLE_BITS-1:0] samp_q;

	logic signed [SUMW-1:0] sum_q, mean_q;
	logic signed [SAMPLE_BITS-1:0] mn_q, mx_q, prv_q;
	logic signed [SAMPLE_BITS+1:0] pd_q, vmin_q, vmax_q, amin_q, amax_q, vel_q, acc_q;
	logic [SQW-1:0] sq_q, dev_q;
	logic rd_ok_q;

	// Shared divider / root state
	logic [DW-1:0] num_q, rem_q, quo_q;
	logic [$clog2(QSTEPS+1)-1:0] cnt_q;
	logic neg_q;
	logic [RW-1:0] root_q, dres_q;
	logic [15:0] std_q, rms_q;

	logic out_v_q;
	logic [207:0] out_q;

	logic wr_cfg;
	assign pready = 1'b1;
	assign wr_cfg = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH);
	assign prdata = {{(32-CW){1'b0}}, len_q};
	assign len_w  = pwdata[LenBits-1:0];

	assign s_tready = (state_q == ST_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;
	assign s_in     = s_tdata[SAMPLE_BITS-1:0];

	// Physical address of window element k in window order
	logic [CW:0] addr_sum;
	logic [AW-1:0] rd_addr;
	always_comb begin
		addr_sum = {1'b0, wp_q} + {1'b0, k_q};
		if (addr_sum >= {1'b0, len_q})
			addr_sum = addr_sum - {1'b0, len_q};
		rd_addr = addr_sum[AW-1:0];
	end

	// Memory: one write, one registered read per cycle
	logic mem_we;
	logic [AW-1:0] mem_wa;
	logic [SAMPLE_BITS-1:0] mem_wd;
	always_comb begin
		mem_we = 1'b0;
		mem_wa = rd_addr;
		mem_wd = samp_q;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q[AW-1:0];
			mem_wd = '0;
		end else if (state_q == ST_READ && !clear_q) begin
			mem_we = 1'b1;
			mem_wa = wp_q[AW-1:0];
		end
	end
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_s1 <= mem[rd_addr];
	end

	// Shared arithmetic: divider step and root step operands
	logic [DW-1:0] rem_sh, rem_sub;
	logic rem_ge;
	logic [RW+1:0] trial;
	logic [RW+1:0] rrem_sh;
	always_comb begin
		rem_sh  = {rem_q[DW-2:0], num_q[DW-1]};
		rem_ge  = rem_sh >= DW'(len_q);
		rem_sub = rem_sh - DW'(len_q);
		rrem_sh = {dres_q, num_q[DW-1:DW-2]};
		trial   = {root_q, 2'b01};
	end

	logic signed [SAMPLE_BITS-1:0] s_cur;
	logic signed [SAMPLE_BITS+1:0] d_cur, a_cur;
	logic signed [SUMW-1:0] e_cur;
	logic signed [SUMW-1:0] sum_nx;
	logic [CW-1:0] kr;
	always_comb begin
		s_cur  = rd_s1;
		d_cur  = (SAMPLE_BITS+2)'(s_cur) - (SAMPLE_BITS+2)'(prv_q);
		a_cur  = d_cur - pd_q;
		e_cur  = SUMW'(s_cur) - mean_q;
		sum_nx = sum_q + SUMW'(s_cur);
		kr     = k_q - CW'(1);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			op_q    <= OP_MEAN;
			len_q   <= CW'(MinLength);
			wp_q    <= '0;
			k_q     <= '0;
			clr_q   <= '0;
			cnt_q   <= '0;
			rd_ok_q <= 1'b0;
			out_v_q <= 1'b0;
			clear_q <= 1'b0;
		end else begin
			if (out_v_q && m_tready)
				out_v_q <= 1'b0;
			if (wr_cfg) begin
				// Saturate and restart with a fresh window
				if (len_w < LenBits'(MinLength))
					len_q <= CW'(MinLength);
				else if (32'(len_w) > 32'(WINDOW_MAX))
					len_q <= CW'(WINDOW_MAX);
				else
					len_q <= CW'(len_w);
				wp_q    <= '0;
				clr_q   <= '0;
				state_q <= ST_CLEAR;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (s_tvalid && s_tready) begin
							clear_q <= s_tuser;
							clr_q   <= '0;
							state_q <= ST_READ;
						end
					end
					ST_CLEAR: begin
						clr_q <= clr_q + CW'(1);
						if (clr_q == CW'(WINDOW_MAX - 1)) begin
							wp_q <= '0;
							state_q <= clear_q ? ST_READ : ST_IDLE;
						end
					end
					ST_READ: begin
						// Push or clear, then start the first scan
						if (clear_q && clr_q == '0) begin
							state_q <= ST_CLEAR;
						end else begin
							clear_q <= 1'b0;
							if (!clear_q)
								wp_q <= (wp_q + CW'(1) == len_q) ? '0 : wp_q + CW'(1);
							k_q     <= '0;
							rd_ok_q <= 1'b0;
							state_q <= ST_SCAN1;
						end
					end
					ST_SCAN1: begin
						rd_ok_q <= 1'b1;
						if (k_q != len_q)
							k_q <= k_q + CW'(1);
						if (rd_ok_q && kr == len_q - CW'(1)) begin
							num_q   <= sum_nx[SUMW-1] ? DW'(-sum_nx) : DW'(sum_nx);
							neg_q   <= sum_nx[SUMW-1];
							rem_q   <= '0;
							cnt_q   <= '0;
							op_q    <= OP_MEAN;
							state_q <= ST_DIV;
						end
					end
					ST_DIV: begin
						// One quotient bit per cycle
						num_q <= {num_q[DW-2:0], 1'b0};
						rem_q <= rem_ge ? rem_sub : rem_sh;
						quo_q <= {quo_q[DW-2:0], rem_ge};
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == ($bits(cnt_q))'(QSTEPS - 1)) begin
							cnt_q <= '0;
							unique case (op_q)
								OP_MEAN: begin
									k_q     <= '0;
									rd_ok_q <= 1'b0;
									state_q <= ST_SCAN2;
								end
								OP_DEV, OP_SQ: begin
									num_q   <= {quo_q[DW-2:0], rem_ge};
									root_q  <= '0;
									dres_q  <= '0;
									state_q <= ST_SQRT;
								end
								default: state_q <= ST_IDLE;
							endcase
						end
					end
					ST_SCAN2: begin
						rd_ok_q <= 1'b1;
						if (k_q != len_q)
							k_q <= k_q + CW'(1);
						if (rd_ok_q && kr == len_q - CW'(1)) begin
							state_q <= ST_DIVSQ;
						end
					end
					ST_DIVSQ: begin
						num_q   <= (op_q == OP_MEAN) ? dev_q : sq_q;
						op_q    <= (op_q == OP_MEAN) ? OP_DEV : OP_SQ;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
					ST_SQRT: begin
						// One root bit per cycle, two radicand bits consumed
						num_q <= {num_q[DW-3:0], 2'b00};
						if (rrem_sh >= trial) begin
							dres_q <= RW'(rrem_sh - trial);
							root_q <= {root_q[RW-2:0], 1'b1};
						end else begin
							dres_q <= RW'(rrem_sh);
							root_q <= {root_q[RW-2:0], 1'b0};
						end
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == ($bits(cnt_q))'(QSTEPS/2 - 1)) begin
							cnt_q <= '0;
							state_q <= (op_q == OP_DEV) ? ST_DIVSQ : ST_OUT;
						end
					end
					ST_OUT: begin
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// Datapath registers
	logic [RW-1:0] root_fin;
	assign root_fin = (rrem_sh >= trial) ? {root_q[RW-2:0], 1'b1} : {root_q[RW-2:0], 1'b0};
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid && s_tready)
			samp_q <= s_in;
		if (state_q == ST_READ) begin
			sum_q <= '0;
			sq_q  <= '0;
			dev_q <= '0;
		end
		if (state_q == ST_SCAN1 && rd_ok_q && kr < len_q) begin
			sum_q <= sum_nx;
			sq_q  <= sq_q + SQW'(s_cur * s_cur);
			prv_q <= s_cur;
			if (kr == '0 || s_cur < mn_q) mn_q <= s_cur;
			if (kr == '0 || s_cur > mx_q) mx_q <= s_cur;
			if (kr != '0) begin
				pd_q <= d_cur;
				vel_q <= d_cur;
				if (kr == CW'(1) || d_cur < vmin_q) vmin_q <= d_cur;
				if (kr == CW'(1) || d_cur > vmax_q) vmax_q <= d_cur;
				if (kr >= CW'(2)) begin
					acc_q <= a_cur;
					if (kr == CW'(2) || a_cur < amin_q) amin_q <= a_cur;
					if (kr == CW'(2) || a_cur > amax_q) amax_q <= a_cur;
				end
			end
		end
		if (state_q == ST_DIV && op_q == OP_MEAN && cnt_q == ($bits(cnt_q))'(QSTEPS - 1))
			mean_q <= neg_q ? -SUMW'({quo_q[DW-2:0], rem_ge}) : SUMW'({quo_q[DW-2:0], rem_ge});
		if (state_q == ST_SCAN2 && rd_ok_q && kr < len_q)
			dev_q <= dev_q + SQW'(e_cur * e_cur);
		if (state_q == ST_SQRT && cnt_q == ($bits(cnt_q))'(QSTEPS/2 - 1)) begin
			if (op_q == OP_DEV) std_q <= 16'(root_fin);
			else rms_q <= 16'(root_fin);
		end
		if (state_q == ST_OUT)
			out_q <= {1'b0, 18'(amax_q), 18'(amin_q), 17'(vmax_q), 17'(vmin_q), rms_q, std_q,
				16'(mean_q), 22'(sum_q), 16'(mx_q), 16'(mn_q), 18'(acc_q), 17'(vel_q)};
	end

	logic unused_ok;
	assign unused_ok = ^{pwdata[31:LenBits], paddr[1:0]};

endmodule

// File: rtl/core/sws_checker.sv
// Checker: port-level properties of the sliding window statistics block, with its bind.
module sws_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [207:0] m_tdata,
	input logic        pready
);
	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	// No new input while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("ready with pending result");
	// An accepted item blocks further input next cycle
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("back to back accept");
	// The top fill bit of every result is zero
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[207]) else $error("fill bit set");
	a_rdy: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind sliding_window_statistics sws_checker u_sws_checker (.*);

// File: test/sliding_window_statistics_tb.sv
// Testbench for sliding_window_statistics: APB length setup, stream stimulus, scoreboard.
module sliding_window_statistics_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_FIELDS = 12;
	localparam int FIELD_LO [NUM_FIELDS] = '{0, 17, 35, 51, 67, 89, 105, 121, 137, 154, 171, 189};
	localparam int FIELD_W [NUM_FIELDS] = '{17, 18, 16, 16, 22, 16, 16, 16, 17, 17, 18, 18};
	localparam string FIELD_NAME [NUM_FIELDS] = '{"velocity", "acceleration", "window_min",
		"window_max", "window_sum", "window_mean", "std_dev", "root_mean_square",
		"min_velocity", "max_velocity", "min_acceleration", "max_acceleration"};
	localparam int LONG_HOLD_CYCLES = 2000;
	localparam int SETTLE_CYCLES = 400;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [15:0]  s_tdata;  // [15:0] sample
	logic         s_tuser;  // [0] clear_window
	logic         m_tvalid;
	logic         m_tready;
	// [16:0] velocity, [34:17] acceleration, [50:35] window_min, [66:51] window_max,
	// [88:67] window_sum, [104:89] window_mean, [120:105] std_dev,
	// [136:121] root_mean_square, [153:137] min_velocity, [170:154] max_velocity,
	// [188:171] min_acceleration, [206:189] max_acceleration, [207] zero fill
	logic [207:0] m_tdata;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	sliding_window_statistics dut (.*);

	// Shadow of the block state
	longint       win_store [64];
	int           win_ptr;
	int           win_len;

	logic [207:0] stats_pending [$];
	int           mismatches;
	int           items_sent;
	int           results_seen;
	int           clears_sent;
	int           lengths_used;
	bit           quiet;
	bit           long_hold;

	typedef struct {
		logic [15:0] smp;
		bit          clr;
		bit          zero_known;
	} stim_row_t;

	stim_row_t directed_rows [] = '{
		'{16'h7FFF, 0, 0}, '{16'h8000, 0, 0}, '{16'h7FFF, 0, 0}, '{16'h8000, 0, 0},
		'{16'h7FFF, 0, 0}, '{16'h0000, 1, 1}, '{16'h0001, 0, 0}, '{16'hFFFF, 0, 0},
		'{16'h8000, 0, 0}, '{16'h8000, 0, 0}, '{16'h8000, 0, 0}, '{16'h7FFF, 1, 1},
		'{16'h00FF, 0, 0}, '{16'hFF00, 0, 0}, '{16'h5555, 0, 0}, '{16'hAAAA, 0, 0},
		'{16'h0000, 0, 0}, '{16'h7FFF, 0, 0}, '{16'h7FFF, 0, 0}, '{16'h0000, 1, 1}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("simulation failed");
		$finish;
	end

	function automatic void clear_shadow();
		foreach (win_store[i]) win_store[i] = 0;
		win_ptr = 0;
	endfunction

	function automatic longint floor_root(longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 17; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v) r = t;
		end
		return longint'(r);
	endfunction

	function automatic longint at_order(int k);
		return win_store[(win_ptr + k) % win_len];
	endfunction

	// Push one sample (or clear) into the shadow window and compute the statistics
	function automatic logic [207:0] window_stats(logic [15:0] smp, bit clr);
		longint s, mn, mx, sum, mean, d, prev_d, a, vmin, vmax, amin, amax, e, vel, acc;
		longint unsigned sq, dev;
		if (clr) clear_shadow();
		else begin
			win_store[win_ptr] = longint'($signed(smp));
			win_ptr = (win_ptr + 1) % win_len;
		end
		mn = at_order(0);
		mx = mn;
		sum = 0;
		sq = 0;
		dev = 0;
		prev_d = 0;
		vmin = 0; vmax = 0; amin = 0; amax = 0;
		for (int k = 0; k < win_len; k++) begin
			s = at_order(k);
			if (s < mn) mn = s;
			if (s > mx) mx = s;
			sum += s;
			sq += s * s;
			if (k >= 1) begin
				d = s - at_order(k - 1);
				if (k == 1 || d < vmin) vmin = d;
				if (k == 1 || d > vmax) vmax = d;
				if (k >= 2) begin
					a = d - prev_d;
					if (k == 2 || a < amin) amin = a;
					if (k == 2 || a > amax) amax = a;
				end
				prev_d = d;
			end
		end
		mean = sum / win_len;
		for (int k = 0; k < win_len; k++) begin
			e = at_order(k) - mean;
			dev += e * e;
		end
		vel = at_order(win_len - 1) - at_order(win_len - 2);
		acc = vel - (at_order(win_len - 2) - at_order(win_len - 3));
		return {1'b0, amax[17:0], amin[17:0], vmax[16:0], vmin[16:0],
			16'(floor_root(sq / win_len)), 16'(floor_root(dev / win_len)),
			mean[15:0], sum[21:0], mx[15:0], mn[15:0], acc[17:0], vel[16:0]};
	endfunction

	// Receive side: check each transfer against the oldest expectation, then stall at random or for one long hold
	initial begin
		int stall_left;
		logic [207:0] want;
		longint unsigned mask, got_f, want_f;
		bit bad;
		m_tready <= 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (stats_pending.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %h", m_tdata);
				end else begin
					want = stats_pending.pop_front();
					bad = 0;
					for (int f = 0; f < NUM_FIELDS; f++) begin
						mask = (64'd1 << FIELD_W[f]) - 1;
						got_f = 64'(m_tdata >> FIELD_LO[f]) & mask;
						want_f = 64'(want >> FIELD_LO[f]) & mask;
						if (got_f !== want_f) begin
							bad = 1;
							if (mismatches < 10)
								$display("result %0d %s: expected %h got %h", results_seen,
									FIELD_NAME[f], want_f, got_f);
						end
					end
					if (bad) mismatches++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (long_hold) begin
				long_hold = 0;
				stall_left = LONG_HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic drain();
		while (stats_pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == sws_pkg::REG_WINDOW_LENGTH) begin
			win_len = value[6:0];
			if (win_len < sws_pkg::MinLength) win_len = sws_pkg::MinLength;
			if (win_len > 64) win_len = 64;
			clear_shadow();
			lengths_used++;
		end
	endtask

	task automatic check_length_readback();
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		paddr <= 3'(sws_pkg::REG_WINDOW_LENGTH);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[6:0] !== 7'(win_len)) begin
			mismatches++;
			if (mismatches <= 10)
				$display("window_length read: expected %0d got %0d", win_len, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Offer one item, hold it until transfer, and record its expected statistics
	task automatic send_item(logic [15:0] smp, bit clr, bit zero_known);
		if (!quiet && s_tvalid && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tuser <= clr;
		do @(posedge clk); while (!s_tready);
		if (zero_known) begin
			void'(window_stats(smp, clr));
			stats_pending.push_back('0);
		end else begin
			stats_pending.push_back(window_stats(smp, clr));
		end
		items_sent++;
		if (clr) clears_sent++;
	endtask

	task automatic idle_sender();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] random_sample(logic [15:0] last);
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			2: return 16'($signed($urandom_range(0, 600)) - 300);
			default: return last + 16'($signed($urandom_range(0, 64)) - 32);
		endcase
	endfunction

	initial begin
		int phase_len;
		logic [15:0] smp;
		logic [31:0] len_value;
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		mismatches = 0;
		items_sent = 0;
		results_seen = 0;
		clears_sent = 0;
		lengths_used = 0;
		quiet = 0;
		long_hold = 0;
		win_len = sws_pkg::MinLength;
		clear_shadow();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		check_length_readback();

		// Directed rows at the reset length of three
		foreach (directed_rows[i])
			send_item(directed_rows[i].smp, directed_rows[i].clr, directed_rows[i].zero_known);
		idle_sender();
		drain();

		// Saturation of the length and a write to an unused address
		apb_write(3'(sws_pkg::REG_WINDOW_LENGTH), 32'd0);
		check_length_readback();
		apb_write(3'd4, 32'd20);
		check_length_readback();
		apb_write(3'(sws_pkg::REG_WINDOW_LENGTH), 32'hFFFF_FFFF);
		check_length_readback();
		foreach (directed_rows[i])
			send_item(directed_rows[i].smp, directed_rows[i].clr, 0);
		idle_sender();
		drain();

		// Random phases, each at its own window length
		smp = '0;
		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: len_value = 32'd3;
				1: len_value = 32'd64;
				2: len_value = 32'd1;
				3: len_value = 32'd100;
				9: len_value = 32'd4;
				default: len_value = $urandom_range(3, 64);
			endcase
			apb_write(3'(sws_pkg::REG_WINDOW_LENGTH), len_value);
			check_length_readback();
			if (phase == 1) long_hold = 1;
			if (phase == 9) quiet = 1;
			phase_len = $urandom_range(150, 165);
			for (int n = 0; n < phase_len; n++) begin
				smp = random_sample(smp);
				send_item(smp, $urandom_range(0, 24) == 0, 0);
			end
			idle_sender();
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d items (%0d clears) over %0d length settings, %0d results checked",
			items_sent, clears_sent, lengths_used, results_seen);
		$display("mismatching results: %0d", mismatches);
		if (mismatches == 0 && stats_pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
